@@ rtl/core/hbs_pkg.sv @@
// Shared constants for the height grid smoother: field widths, operation codes,
// register indexes and register reset values.
// No dependencies; compile first.
package hbs_pkg;

   // Field widths of the request, response and register channels
   localparam int OpW       = 2;
   localparam int ColW      = 7;
   localparam int RowW      = 7;
   localparam int SampleW   = 16;
   localparam int HeightW   = 24;
   localparam int SizeW     = 8;
   localparam int ScaleW    = 16;
   localparam int PassW     = 4;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;

   // Scale is unsigned Q8.8
   localparam int FracW    = 8;
   localparam int ProductW = SampleW + ScaleW;

   // Default grid limits
   localparam int DefMaxWidth  = 128;
   localparam int DefMaxHeight = 128;
   localparam int DefDepth     = DefMaxWidth * DefMaxHeight;

   // Operation codes
   localparam logic [OpW-1:0] OP_WRITE  = 2'd0;
   localparam logic [OpW-1:0] OP_SMOOTH = 2'd1;
   localparam logic [OpW-1:0] OP_READ   = 2'd2;

   // Register indexes
   localparam logic [CsrIndexW-1:0] CSR_GRID_WIDTH    = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_GRID_HEIGHT   = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_SCALE         = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_SMOOTH_PASSES = 2'd3;

   // Register reset values
   localparam logic [SizeW-1:0]  GRID_WIDTH_RESET    = 8'd128;
   localparam logic [SizeW-1:0]  GRID_HEIGHT_RESET   = 8'd128;
   localparam logic [ScaleW-1:0] SCALE_RESET         = 16'd256;
   localparam logic [PassW-1:0]  SMOOTH_PASSES_RESET = 4'd1;

endpackage

@@ rtl/core/hbs_ifs.sv @@
// Valid/ready channel interfaces of the height grid smoother: request,
// response and register write.
// Depends on hbs_pkg.
interface hbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [hbs_pkg::OpW-1:0]       operation;
   logic [hbs_pkg::ColW-1:0]      col;
   logic [hbs_pkg::RowW-1:0]      row;
   logic [hbs_pkg::SampleW-1:0]   sample;

   modport source (output valid, operation, col, row, sample, input ready);
   modport sink   (input valid, operation, col, row, sample, output ready);
endinterface

interface hbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hbs_pkg::HeightW-1:0]   height;
   logic                          error;

   modport source (output valid, height, error, input ready);
   modport sink   (input valid, height, error, output ready);
endinterface

interface hbs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hbs_pkg::CsrIndexW-1:0] index;
   logic [hbs_pkg::CsrDataW-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/hbs_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds one grid of heights; depends on hbs_pkg for default sizes.
module hbs_ram #(
   parameter int DEPTH  = hbs_pkg::DefDepth,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = hbs_pkg::HeightW
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/heightmap_box_smoother.sv @@
// Height grid with scaled writes, reads and 3x3 rounded-mean smoothing passes.
// A smooth runs P passes over a W x H grid; each pass reads the neighbors of every cell on
// the single height RAM read port and writes their rounded mean to the scratch grid, then
// copies the scratch grid back one cell per cycle.
// A new request is taken only once the last one is finished; a request is taken while a response waits.
// Reset: synchronous, clears control and registers to defaults; grid RAMs are not cleared.
module heightmap_box_smoother #(
   parameter int MAX_WIDTH  = hbs_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = hbs_pkg::DefMaxHeight
) (
   input logic        clock,
   input logic        reset,
   hbs_req_if.sink    req_if,
   hbs_rsp_if.source  rsp_if,
   hbs_csr_if.sink    csr_if
);

   localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(Depth);
   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int SumW    = hbs_pkg::HeightW + 4;
   localparam int ProdW   = SumW + 32;
   localparam int RecipShift = 33;
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   // Sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_EXEC      = 4'd1;
   localparam logic [3:0] S_RD_DATA   = 4'd2;
   localparam logic [3:0] S_START     = 4'd3;
   localparam logic [3:0] S_NB        = 4'd4;
   localparam logic [3:0] S_NB_LAST   = 4'd5;
   localparam logic [3:0] S_DIVX      = 4'd6;
   localparam logic [3:0] S_DIVY      = 4'd7;
   localparam logic [3:0] S_STORE     = 4'd8;
   localparam logic [3:0] S_COPY      = 4'd9;
   localparam logic [3:0] S_COPY_LAST = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   // Divide by 1, 2 or 3 (3 through an exact reciprocal multiply)
   function automatic logic [SumW-1:0] div_small(input logic [SumW-1:0] val,
                                                 input logic [1:0] k);
      logic [ProdW-1:0] prod;
      logic [SumW-1:0]  q;
      prod = ProdW'(val) * ProdW'(RECIP3);
      case (k)
         2'd2:    q = val >> 1;
         2'd3:    q = SumW'(prod >> RecipShift);
         default: q = val;
      endcase
      return q;
   endfunction

   logic [3:0]                     state_ff, state_in;
   logic [hbs_pkg::OpW-1:0]        op_ff, op_in;
   logic [hbs_pkg::ColW-1:0]       col_ff, col_in;
   logic [hbs_pkg::RowW-1:0]       row_ff, row_in;
   logic [hbs_pkg::SampleW-1:0]    sample_ff, sample_in;
   logic [hbs_pkg::SizeW-1:0]      grid_width_ff, grid_width_in;
   logic [hbs_pkg::SizeW-1:0]      grid_height_ff, grid_height_in;
   logic [hbs_pkg::ScaleW-1:0]     scale_ff, scale_in;
   logic [hbs_pkg::PassW-1:0]      passes_ff, passes_in;
   logic [hbs_pkg::PassW-1:0]      pass_ff, pass_in;
   logic [XW-1:0]                  x_ff, x_in;
   logic [YW-1:0]                  y_ff, y_in;
   logic [1:0]                     ndx_ff, ndx_in;
   logic [1:0]                     ndy_ff, ndy_in;
   logic                           acc_en_ff, acc_en_in;
   logic [SumW-1:0]                acc_ff, acc_in;
   logic [SumW-1:0]                div_ff, div_in;
   logic                           cp_valid_ff, cp_valid_in;
   logic [AW-1:0]                  cp_addr_ff, cp_addr_in;
   logic [hbs_pkg::HeightW-1:0]    res_height_ff, res_height_in;
   logic                           res_error_ff, res_error_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hbs_pkg::HeightW-1:0]    rsp_height_ff, rsp_height_in;
   logic                           rsp_error_ff, rsp_error_in;

   logic [XW-1:0]                  x_last;
   logic [YW-1:0]                  y_last;
   logic                           op_oob;
   logic [AW-1:0]                  op_addr;
   logic [AW-1:0]                  cell_addr;
   logic [XW-1:0]                  nb_x;
   logic [YW-1:0]                  nb_y;
   logic [AW-1:0]                  nb_addr;
   logic                           nb_inb;
   logic                           last_cell;
   logic [1:0]                     cnt_x, cnt_y;
   logic [2:0]                     half;
   logic [SumW-1:0]                div_q;
   logic [hbs_pkg::ProductW-1:0]   product;

   logic                           h_wr_en, h_rd_en, s_wr_en, s_rd_en;
   logic [AW-1:0]                  h_wr_addr, h_rd_addr, s_wr_addr, s_rd_addr;
   logic [hbs_pkg::HeightW-1:0]    h_wr_data, h_rd_data, s_wr_data, s_rd_data;

   // Height grid and scratch grid
   hbs_ram #(.DEPTH(Depth), .ADDR_W(AW), .DATA_W(hbs_pkg::HeightW)) u_height_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   hbs_ram #(.DEPTH(Depth), .ADDR_W(AW), .DATA_W(hbs_pkg::HeightW)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   // Clamp configured size to the last column and row in use
   always_comb begin
      if (grid_width_ff == '0) begin
         x_last = '0;
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         x_last = XW'(MAX_WIDTH - 1);
      end else begin
         x_last = XW'(grid_width_ff - 8'd1);
      end
      if (grid_height_ff == '0) begin
         y_last = '0;
      end else if (32'(grid_height_ff) > 32'(MAX_HEIGHT)) begin
         y_last = YW'(MAX_HEIGHT - 1);
      end else begin
         y_last = YW'(grid_height_ff - 8'd1);
      end
   end

   // Request cell address and bounds check
   assign op_oob  = (32'(col_ff) > 32'(x_last)) || (32'(row_ff) > 32'(y_last));
   assign op_addr = AW'(row_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign product = hbs_pkg::ProductW'(sample_ff) * hbs_pkg::ProductW'(scale_ff);

   // Scan cell and its neighbor
   assign cell_addr = AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff);
   assign nb_x      = x_ff + XW'(ndx_ff) - XW'(1);
   assign nb_y      = y_ff + YW'(ndy_ff) - YW'(1);
   assign nb_addr   = AW'(nb_y) * AW'(MAX_WIDTH) + AW'(nb_x);
   assign nb_inb    = !(ndx_ff == 2'd0 && x_ff == '0) && !(ndx_ff == 2'd2 && x_ff == x_last) &&
                      !(ndy_ff == 2'd0 && y_ff == '0) && !(ndy_ff == 2'd2 && y_ff == y_last);
   assign last_cell = (x_ff == x_last) && (y_ff == y_last);

   // Neighbors in bounds per axis, and the rounding bias for their product
   assign cnt_x = 2'd1 + 2'(x_ff != '0) + 2'(x_ff != x_last);
   assign cnt_y = 2'd1 + 2'(y_ff != '0) + 2'(y_ff != y_last);
   assign half  = 3'((4'(cnt_x) * 4'(cnt_y)) >> 1);

   // Divider: by the column count first, then by the row count
   assign div_q = (state_ff == S_DIVX) ? div_small(acc_ff, cnt_x) : div_small(div_ff, cnt_y);

   // RAM port selection
   always_comb begin
      h_wr_en   = 1'b0;
      h_wr_addr = op_addr;
      h_wr_data = product[hbs_pkg::FracW +: hbs_pkg::HeightW];
      h_rd_en   = 1'b0;
      h_rd_addr = nb_addr;
      s_wr_en   = 1'b0;
      s_wr_addr = cell_addr;
      s_wr_data = div_ff[hbs_pkg::HeightW-1:0];
      s_rd_en   = 1'b0;
      s_rd_addr = cell_addr;
      case (state_ff)
         S_EXEC: begin
            if (op_ff == hbs_pkg::OP_WRITE && !op_oob) begin
               h_wr_en = 1'b1;
            end
            if (op_ff == hbs_pkg::OP_READ && !op_oob) begin
               h_rd_en   = 1'b1;
               h_rd_addr = op_addr;
            end
         end
         S_NB:    h_rd_en = nb_inb;
         S_STORE: s_wr_en = 1'b1;
         S_COPY:  s_rd_en = 1'b1;
         default: ;
      endcase
      // Copy back: write the scratch word read in the previous cycle
      if (cp_valid_ff) begin
         h_wr_en   = 1'b1;
         h_wr_addr = cp_addr_ff;
         h_wr_data = s_rd_data;
      end
   end

   // Register writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      scale_in       = scale_ff;
      passes_in      = passes_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            hbs_pkg::CSR_GRID_WIDTH:    grid_width_in  = csr_if.data[hbs_pkg::SizeW-1:0];
            hbs_pkg::CSR_GRID_HEIGHT:   grid_height_in = csr_if.data[hbs_pkg::SizeW-1:0];
            hbs_pkg::CSR_SCALE:         scale_in       = csr_if.data[hbs_pkg::ScaleW-1:0];
            hbs_pkg::CSR_SMOOTH_PASSES: passes_in      = csr_if.data[hbs_pkg::PassW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      sample_in     = sample_ff;
      pass_in       = pass_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ndx_in        = ndx_ff;
      ndy_in        = ndy_ff;
      acc_en_in     = 1'b0;
      acc_in        = acc_ff;
      div_in        = div_ff;
      cp_valid_in   = 1'b0;
      cp_addr_in    = cell_addr;
      res_height_in = res_height_ff;
      res_error_in  = res_error_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_height_in = rsp_height_ff;
      rsp_error_in  = rsp_error_ff;

      // Drop the response once taken
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in     = req_if.operation;
               col_in    = req_if.col;
               row_in    = req_if.row;
               sample_in = req_if.sample;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            res_height_in = '0;
            res_error_in  = 1'b0;
            state_in      = S_DONE;
            case (op_ff)
               hbs_pkg::OP_WRITE: res_error_in = op_oob;
               hbs_pkg::OP_READ: begin
                  res_error_in = op_oob;
                  if (!op_oob) begin
                     state_in = S_RD_DATA;
                  end
               end
               hbs_pkg::OP_SMOOTH: begin
                  if (passes_ff != '0) begin
                     x_in     = '0;
                     y_in     = '0;
                     pass_in  = '0;
                     state_in = S_START;
                  end
               end
               default: ;
            endcase
         end
         S_RD_DATA: begin
            res_height_in = h_rd_data;
            state_in      = S_DONE;
         end
         // Seed the sum with the rounding bias of this cell
         S_START: begin
            acc_in   = SumW'(half);
            ndx_in   = '0;
            ndy_in   = '0;
            state_in = S_NB;
         end
         // Visit one neighbor a cycle and read it if in bounds; accumulate the previous one
         S_NB: begin
            acc_en_in = nb_inb;
            if (acc_en_ff) begin
               acc_in = acc_ff + SumW'(h_rd_data);
            end
            if (ndx_ff == 2'd2) begin
               ndx_in = '0;
               ndy_in = ndy_ff + 2'd1;
               if (ndy_ff == 2'd2) begin
                  state_in = S_NB_LAST;
               end
            end else begin
               ndx_in = ndx_ff + 2'd1;
            end
         end
         S_NB_LAST: begin
            if (acc_en_ff) begin
               acc_in = acc_ff + SumW'(h_rd_data);
            end
            state_in = S_DIVX;
         end
         S_DIVX: begin
            div_in   = div_q;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            div_in   = div_q;
            state_in = S_STORE;
         end
         // Scratch write happens here; advance the scan
         S_STORE: begin
            if (last_cell) begin
               x_in     = '0;
               y_in     = '0;
               state_in = S_COPY;
            end else begin
               if (x_ff == x_last) begin
                  x_in = '0;
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
               state_in = S_START;
            end
         end
         S_COPY: begin
            cp_valid_in = 1'b1;
            cp_addr_in  = cell_addr;
            if (last_cell) begin
               x_in     = '0;
               y_in     = '0;
               state_in = S_COPY_LAST;
            end else if (x_ff == x_last) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         S_COPY_LAST: begin
            if (hbs_pkg::PassW'(pass_ff + 4'd1) == passes_ff) begin
               pass_in  = '0;
               state_in = S_DONE;
            end else begin
               pass_in  = pass_ff + 4'd1;
               state_in = S_START;
            end
         end
         // Hold the result until the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = res_height_ff;
               rsp_error_in  = res_error_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pass_ff        <= '0;
         x_ff           <= '0;
         y_ff           <= '0;
         ndx_ff         <= '0;
         ndy_ff         <= '0;
         acc_en_ff      <= 1'b0;
         cp_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= hbs_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= hbs_pkg::GRID_HEIGHT_RESET;
         scale_ff       <= hbs_pkg::SCALE_RESET;
         passes_ff      <= hbs_pkg::SMOOTH_PASSES_RESET;
      end else begin
         state_ff       <= state_in;
         pass_ff        <= pass_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         ndx_ff         <= ndx_in;
         ndy_ff         <= ndy_in;
         acc_en_ff      <= acc_en_in;
         cp_valid_ff    <= cp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         scale_ff       <= scale_in;
         passes_ff      <= passes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      sample_ff     <= sample_in;
      acc_ff        <= acc_in;
      div_ff        <= div_in;
      cp_addr_ff    <= cp_addr_in;
      res_height_ff <= res_height_in;
      res_error_ff  <= res_error_in;
      rsp_height_ff <= rsp_height_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.height = rsp_height_ff;
   assign rsp_if.error  = rsp_error_ff;
   assign csr_if.ready  = 1'b1;

endmodule

@@ rtl/core/hbs_checker.sv @@
// Port-level assertions for the height grid smoother, attached by bind.
// Depends on hbs_pkg and heightmap_box_smoother.
module hbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hbs_pkg::HeightW-1:0] rsp_height,
   input logic                        rsp_error
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height) && $stable(rsp_error))
      else $error("response changed while stalled");

   // Drop any response on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An error response carries no height
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_height == '0)
      else $error("error response with nonzero height");

   // Not ready in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

endmodule

bind heightmap_box_smoother hbs_checker u_hbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_height (rsp_if.height),
   .rsp_error  (rsp_if.error)
);
